>>> src/command_frame_receiver_responder_core_macros.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef COMMAND_FRAME_RECEIVER_RESPONDER_CORE_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CFRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CFRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cfrr_pkg.sv
// Types, constants and functions of the command frame receiver.
package cfrr_pkg;

  localparam logic [7:0] START_MARK = 8'h01;
  localparam logic [7:0] STOP_MARK  = 8'hBB;
  localparam logic [7:0] RESP_CMD   = 8'h03;
  localparam logic [7:0] RESP_ACK   = 8'h01;
  localparam logic [7:0] ADDR_NONE  = 8'hFF;
  localparam logic [7:0] MAX_LEN_RESET = 8'd251;
  localparam int unsigned RESP_LEN  = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDR_ERR  = 3'd1;
  localparam logic [2:0] ST_MODE_ERR  = 3'd2;
  localparam logic [2:0] ST_LEN_ERR   = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] addr;
  } cfrr_result_t;

  function automatic cfrr_result_t cfrr_judge(input logic [7:0] len,
                                              input logic [7:0] addr,
                                              input logic [7:0] mode);
    cfrr_result_t r;
    r.status = ST_OK;
    r.addr   = addr;
    if (len < 8'd3) begin
      r.status = ST_TOO_SHORT;
      r.addr   = ADDR_NONE;
    end else if (len == 8'd5) begin
      if (addr != 8'h01 && addr != 8'h02) begin
        r.status = ST_ADDR_ERR;
      end else if (mode != 8'h03 && mode != 8'h04) begin
        r.status = ST_MODE_ERR;
      end
    end else if (len != 8'd4 && len != 8'd6) begin
      r.status = ST_LEN_ERR;
    end
    return r;
  endfunction

  function automatic logic [7:0] cfrr_resp_byte(input logic [2:0] k,
                                                input cfrr_result_t r);
    logic [7:0] b;
    case (k)
      3'd0, 3'd1: b = START_MARK;
      3'd2:       b = RESP_CMD;
      3'd3:       b = RESP_ACK;
      3'd4:       b = {5'd0, r.status};
      3'd5:       b = r.addr;
      default:    b = STOP_MARK;
    endcase
    return b;
  endfunction

endpackage

>>> src/cfrr_front.sv
// Front end: byte-level frame parser, length limit register and frame check.
module cfrr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cfrr_pkg::cfrr_result_t push_data
);
  import cfrr_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_START2  = 6'b000010,
    PH_LENGTH  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_STOP1   = 6'b010000,
    PH_STOP2   = 6'b100000
  } phase_t;

  phase_t     phase;
  logic [7:0] max_len;
  logic [7:0] payload_count;
  logic [7:0] payload_length;
  logic [7:0] address_byte;
  logic [7:0] mode_byte;
  logic [7:0] count_next;
  logic       in_fire;

  assign in_ready   = (phase != PH_STOP2) || push_ready;
  assign in_fire    = in_valid && in_ready;
  assign count_next = payload_count + 8'd1;
  assign push_valid = in_fire && (phase == PH_STOP2) && (rx_data == STOP_MARK);
  assign push_data  = cfrr_judge(payload_length, address_byte, mode_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      max_len        <= MAX_LEN_RESET;
      payload_count  <= 8'd0;
      payload_length <= 8'd0;
      address_byte   <= ADDR_NONE;
      mode_byte      <= 8'd0;
    end else begin
      if (cfg_valid) begin
        max_len <= cfg_data;
      end
      if (in_fire) begin
        case (phase)
          PH_IDLE: begin
            if (rx_data == START_MARK) phase <= PH_START2;
          end
          PH_START2: begin
            phase <= (rx_data == START_MARK) ? PH_LENGTH : PH_IDLE;
          end
          PH_LENGTH: begin
            payload_length <= rx_data;
            payload_count  <= 8'd0;
            if (rx_data > max_len) begin
              phase <= PH_IDLE;
            end else if (rx_data == 8'd0) begin
              phase <= PH_STOP1;
            end else begin
              phase <= PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            payload_count <= count_next;
            if (count_next == 8'd1) begin
              address_byte <= rx_data;
            end else if (count_next == 8'd3) begin
              mode_byte <= rx_data;
            end
            if (count_next == payload_length) phase <= PH_STOP1;
          end
          PH_STOP1: begin
            phase <= (rx_data == STOP_MARK) ? PH_STOP2 : PH_IDLE;
          end
          PH_STOP2: begin
            phase <= PH_IDLE;
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

>>> src/cfrr_queue.sv
// Small flip-flop queue of checked frames between front and back end.
module cfrr_queue #(
  parameter int unsigned DEPTH = cfrr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  cfrr_pkg::cfrr_result_t push_data,
  output logic                   pop_valid,
  input  logic                   pop,
  output cfrr_pkg::cfrr_result_t pop_data
);
  import cfrr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cfrr_result_t    slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/cfrr_back.sv
// Back end: plays out the eight-byte response of each queued frame.
module cfrr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  cfrr_pkg::cfrr_result_t head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             response_byte,
  output logic                   response_last,
  output logic [2:0]             check_status,
  output logic [7:0]             device_address
);
  import cfrr_pkg::*;

  localparam logic [2:0] LastIdx = 3'(RESP_LEN - 1);

  logic [2:0] byte_idx;
  logic       load;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (byte_idx == LastIdx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      byte_idx  <= byte_idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      response_byte  <= cfrr_resp_byte(byte_idx, head_data);
      response_last  <= (byte_idx == LastIdx);
      check_status   <= head_data.status;
      device_address <= head_data.addr;
    end
  end

endmodule

>>> src/command_frame_receiver_responder_core.sv
// Top level of the command frame receiver and responder.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   cfg     | in        | cfg_valid / cfg_ready   | cfg_data (max payload length)
//   in      | in        | in_valid / in_ready     | rx_data
//   out     | out       | out_valid / out_ready   | response_byte, response_last,
//           |           |                         | check_status, device_address
//
// The parser takes one byte per cycle while in_ready is high. Once the second stop
// byte of a frame is accepted, its result enters the queue, and the back end then
// registers its eight response bytes, one per cycle while out_ready is high. Up to
// QUEUE_DEPTH checked frames wait between parser and emitter; in_ready falls only in
// the second-stop phase while that queue is full. Synchronous reset clears parser
// state, queue and output valid; cfg_ready is always high.
module command_frame_receiver_responder_core #(
  parameter int unsigned QUEUE_DEPTH = cfrr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] response_byte,
  output logic       response_last,
  output logic [2:0] check_status,
  output logic [7:0] device_address
);
  import cfrr_pkg::*;

  logic         push_valid;
  logic         push_ready;
  cfrr_result_t push_data;
  logic         head_valid;
  cfrr_result_t head_data;
  logic         pop;

  assign cfg_ready = 1'b1;

  cfrr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_data    (rx_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cfrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head_data)
  );

  cfrr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .response_byte  (response_byte),
    .response_last  (response_last),
    .check_status   (check_status),
    .device_address (device_address)
  );

endmodule

>>> src/cfrr_checker.sv
// Port-level checker of the command frame receiver, bound to the top level.
`include "command_frame_receiver_responder_core_macros.svh"

module cfrr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] response_byte,
  input logic       response_last,
  input logic [2:0] check_status,
  input logic [7:0] device_address
);
  import cfrr_pkg::*;

  `CFRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(response_byte) && $stable(response_last), "response transaction changed while stalled")

  `CFRR_ASSERT_NOW(a_last_is_stop, out_valid && response_last, response_byte == STOP_MARK, "last response byte is not a stop mark")

  `CFRR_ASSERT_NOW(a_short_addr, out_valid && check_status == ST_TOO_SHORT, device_address == ADDR_NONE, "short frame carries an address")

  `CFRR_ASSERT_NEXT(a_frame_status, out_valid && out_ready && !response_last, !out_valid || check_status == $past(check_status), "status changed inside a response frame")

endmodule

bind command_frame_receiver_responder_core cfrr_checker u_cfrr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .response_byte  (response_byte),
  .response_last  (response_last),
  .check_status   (check_status),
  .device_address (device_address)
);

>>> test/command_frame_receiver_responder_core_tb.sv
// Self-checking testbench for command_frame_receiver_responder_core: directed and random framed byte streams.
module command_frame_receiver_responder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfrr_pkg::*;

  localparam logic [7:0] ADDR_ONE    = 8'h01;
  localparam logic [7:0] ADDR_TWO    = 8'h02;
  localparam logic [7:0] MODE_THREE  = 8'h03;
  localparam logic [7:0] MODE_FOUR   = 8'h04;
  localparam logic [7:0] LEN_MIN     = 8'd3;
  localparam logic [7:0] LEN_FOUR    = 8'd4;
  localparam logic [7:0] LEN_CHECKED = 8'd5;
  localparam logic [7:0] LEN_SIX     = 8'd6;
  localparam int PHASE_BYTES = 88;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START2  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_STOP1   = 3'd4,
    PH_STOP2   = 3'd5
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
    logic [7:0] addr;
  } resp_byte_t;

  class frame_scoreboard;
    parse_phase_t phase;
    logic [7:0]   count;
    logic [7:0]   length;
    logic [7:0]   addr_byte;
    logic [7:0]   mode_byte;
    logic [7:0]   max_len;
    resp_byte_t   expected[$];
    int           errors;
    int           results;
    int           status_count[8];

    function new();
      phase     = PH_IDLE;
      count     = 8'd0;
      length    = 8'd0;
      addr_byte = ADDR_NONE;
      mode_byte = 8'd0;
      max_len   = MAX_LEN_RESET;
      errors    = 0;
      results   = 0;
    endfunction

    function void queue_response();
      logic [2:0] st;
      logic [7:0] ad;
      logic [7:0] frame[RESP_LEN];
      resp_byte_t r;
      st = ST_OK;
      ad = addr_byte;
      if (length < LEN_MIN) begin
        st = ST_TOO_SHORT;
        ad = ADDR_NONE;
      end else begin
        case (length)
          LEN_CHECKED: begin
            if (addr_byte != ADDR_ONE && addr_byte != ADDR_TWO) st = ST_ADDR_ERR;
            else if (mode_byte != MODE_THREE && mode_byte != MODE_FOUR) st = ST_MODE_ERR;
          end
          LEN_FOUR, LEN_SIX: st = ST_OK;
          default: st = ST_LEN_ERR;
        endcase
      end
      frame = '{START_MARK, START_MARK, RESP_CMD, RESP_ACK, {5'd0, st}, ad,
                STOP_MARK, STOP_MARK};
      for (int k = 0; k < RESP_LEN; k++) begin
        r.data   = frame[k];
        r.last   = (k == RESP_LEN - 1);
        r.status = st;
        r.addr   = ad;
        expected.push_back(r);
      end
      status_count[st]++;
    endfunction

    // one accepted rx byte
    function void note_byte(logic [7:0] b);
      case (phase)
        PH_IDLE:   if (b == START_MARK) phase = PH_START2;
        PH_START2: phase = (b == START_MARK) ? PH_LENGTH : PH_IDLE;
        PH_LENGTH: begin
          length = b;
          count  = 8'd0;
          if (b > max_len) phase = PH_IDLE;
          else if (b == 8'd0) phase = PH_STOP1;
          else phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          count = count + 8'd1;
          if (count == 8'd1) addr_byte = b;
          else if (count == 8'd3) mode_byte = b;
          if (count == length) phase = PH_STOP1;
        end
        PH_STOP1: phase = (b == STOP_MARK) ? PH_STOP2 : PH_IDLE;
        PH_STOP2: begin
          if (b == STOP_MARK) queue_response();
          phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void compare(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [2:0] status,
                               logic [7:0] addr);
      resp_byte_t e;
      if (expected.size() == 0) begin
        $display("%0t: unexpected response transaction, expected none actual %h",
                 $time, data);
        errors++;
        return;
      end
      e = expected.pop_front();
      results++;
      compare("response_byte", e.data, data);
      compare("response_last", {7'd0, e.last}, {7'd0, last});
      compare("check_status", {5'd0, e.status}, {5'd0, status});
      compare("device_address", e.addr, addr);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] response_byte;
  logic       response_last;
  logic [2:0] check_status;
  logic [7:0] device_address;

  frame_scoreboard sb = new();
  bit idle_on = 1'b1;
  int bytes_sent = 0;
  int limits_used = 0;

  command_frame_receiver_responder_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_data        (rx_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .response_byte  (response_byte),
    .response_last  (response_last),
    .check_status   (check_status),
    .device_address (device_address)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[command_frame_receiver_responder_core] ERROR");
    $finish;
  end

  // output side back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(response_byte, response_last, check_status, device_address);
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_data  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_len = v;
    limits_used++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.expected.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [7:0] not_mark(input logic [7:0] m);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == m) b = ~m;
    return b;
  endfunction

  function automatic logic [7:0] pick_of(input logic [7:0] a, input logic [7:0] b);
    case ($urandom_range(0, 2))
      0: return a;
      1: return b;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned n;
    case ($urandom_range(0, 11))
      0: n = 0;
      1: n = 1;
      2: n = 2;
      3: n = 3;
      4, 5: n = 4;
      6, 7, 8: n = 5;
      9: n = 6;
      10: n = $urandom_range(7, 12);
      default: begin
        n = $urandom_range(200, 255);
        if (n <= sb.max_len) n = $urandom_range(7, 16);
      end
    endcase
    return n;
  endfunction

  task automatic send_frame();
    logic [7:0] fb[$];
    int unsigned len;
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = pick_len();
      fb = {START_MARK, START_MARK, len[7:0]};
      if (len > sb.max_len) begin
        repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < len; i++) begin
          case (i)
            0: fb.push_back(pick_of(ADDR_ONE, ADDR_TWO));
            2: fb.push_back(pick_of(MODE_THREE, MODE_FOUR));
            default: fb.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        fb.push_back(STOP_MARK);
        fb.push_back(STOP_MARK);
        if (kind == 1) begin
          case ($urandom_range(0, 3))
            0: fb[1] = not_mark(START_MARK);
            1: fb[fb.size() - 2] = not_mark(STOP_MARK);
            2: fb[fb.size() - 1] = not_mark(STOP_MARK);
            default: begin
              cut = $urandom_range(2, fb.size() - 2);
              fb = fb[0:cut];
            end
          endcase
        end
      end
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [7:0] limits[5];
    int start_count;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = 8'd0;
    in_valid  = 1'b0;
    rx_data   = 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero length, bad second start, extreme bytes, bad second stop, length over limit
    directed = {START_MARK, START_MARK, 8'h00, STOP_MARK, STOP_MARK,
                START_MARK, 8'h00,
                START_MARK, START_MARK, LEN_FOUR, 8'hFF, 8'h00, 8'h02, 8'hFF,
                STOP_MARK, STOP_MARK,
                START_MARK, START_MARK, 8'h01, 8'h07, STOP_MARK, 8'h00,
                START_MARK, START_MARK, 8'hFF};
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    limits = '{8'd255, 8'd0, LEN_CHECKED, 8'($urandom_range(6, 40)), MAX_LEN_RESET};
    foreach (limits[p]) begin
      if (p == 4) idle_on = 1'b0;
      write_limit(limits[p]);
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_BYTES) send_frame();
      drain();
    end

    if (sb.expected.size() != 0) begin
      $display("%0t: leftover responses, expected 0 pending actual %0d",
               $time, sb.expected.size());
      sb.errors++;
    end
    $display("Sent %0d rx bytes under %0d max-length settings; checked %0d response bytes.",
             bytes_sent, limits_used, sb.results);
    $display("Frames by status: ok %0d, addr %0d, mode %0d, length %0d, short %0d.",
             sb.status_count[ST_OK], sb.status_count[ST_ADDR_ERR],
             sb.status_count[ST_MODE_ERR], sb.status_count[ST_LEN_ERR],
             sb.status_count[ST_TOO_SHORT]);
    if (sb.errors == 0) begin
      $display("[command_frame_receiver_responder_core] OK");
    end else begin
      $display("[command_frame_receiver_responder_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/cfrr_pkg.sv
src/cfrr_front.sv
src/cfrr_queue.sv
src/cfrr_back.sv
src/command_frame_receiver_responder_core.sv
src/cfrr_checker.sv
test/command_frame_receiver_responder_core_tb.sv
